@@ hw/rtl/pscp_pkg.sv @@
// Shared types and constants for the closest-pair point store.
// Holds the operation and status codes and the ring control struct.
// No dependencies.
package pscp_pkg;

	localparam int FIELD_BITS = 16;
	localparam int COUNT_BITS = 7;

	typedef enum logic [1:0] {
		FN_ADD     = 2'd0,
		FN_REMOVE  = 2'd1,
		FN_CLOSEST = 2'd2,
		FN_NEAREST = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef struct packed {
		logic rot;
		logic load;
	} ring_ctl_t;

endpackage

@@ hw/rtl/pscp_cell.sv @@
// One cell of the point ring: holds a single stored point.
// Rotates towards the head within a limit, or loads a new point.
// Depends on pscp_pkg.
module pscp_cell #(
	parameter int COORD_BITS = 16,
	parameter int CNT_W      = 7,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  pscp_pkg::ring_ctl_t   ctl,
	input  logic [CNT_W-1:0]      lim,
	input  logic [COORD_BITS-1:0] nb_x,
	input  logic [COORD_BITS-1:0] nb_y,
	input  logic [COORD_BITS-1:0] head_x,
	input  logic [COORD_BITS-1:0] head_y,
	input  logic [COORD_BITS-1:0] ld_x,
	input  logic [COORD_BITS-1:0] ld_y,
	output logic [COORD_BITS-1:0] x,
	output logic [COORD_BITS-1:0] y
);

	localparam logic [CNT_W:0]   IDX_P1 = (CNT_W+1)'(IDX + 1);
	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);

	logic [COORD_BITS-1:0] x_q, y_q;
	logic [CNT_W:0]        lim_e;

	assign lim_e = {1'b0, lim};

	always_ff @(posedge clk) begin
		if (ctl.load && lim == IDX_C) begin
			x_q <= ld_x;
			y_q <= ld_y;
		end else if (ctl.rot) begin
			if (IDX_P1 < lim_e) begin
				x_q <= nb_x;
				y_q <= nb_y;
			end else if (IDX_P1 == lim_e) begin
				x_q <= head_x;
				y_q <= head_y;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

@@ hw/rtl/pscp_dist.sv @@
// Squared-distance unit: a multiply stage, then a sum and compare stage.
// Keeps the first pair with the strictly smallest squared distance.
// Depends on nothing beyond its parameters.
module pscp_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  issue,
	input  logic [COORD_BITS-1:0] ax,
	input  logic [COORD_BITS-1:0] ay,
	input  logic [COORD_BITS-1:0] bx,
	input  logic [COORD_BITS-1:0] by,
	output logic                  found,
	output logic [COORD_BITS-1:0] best_ax,
	output logic [COORD_BITS-1:0] best_ay,
	output logic [COORD_BITS-1:0] best_bx,
	output logic [COORD_BITS-1:0] best_by
);

	localparam int SQ_W = 2 * COORD_BITS;

	logic [COORD_BITS-1:0] dx, dy;
	logic [SQ_W-1:0]       dxw, dyw;
	logic                  v_s1;
	logic [SQ_W-1:0]       sqx_s1, sqy_s1;
	logic [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic [SQ_W:0]         sum;
	logic [SQ_W:0]         best_q;
	logic                  found_q;
	logic [COORD_BITS-1:0] bax_q, bay_q, bbx_q, bby_q;

	always_comb begin
		dx  = (ax > bx) ? ax - bx : bx - ax;
		dy  = (ay > by) ? ay - by : by - ay;
		dxw = SQ_W'(dx);
		dyw = SQ_W'(dy);
		sum = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= dxw * dxw;
		sqy_s1 <= dyw * dyw;
		ax_s1  <= ax;
		ay_s1  <= ay;
		bx_s1  <= bx;
		by_s1  <= by;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (v_s1) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && v_s1 && (!found_q || sum < best_q)) begin
			best_q <= sum;
			bax_q  <= ax_s1;
			bay_q  <= ay_s1;
			bbx_q  <= bx_s1;
			bby_q  <= by_s1;
		end
	end

	assign found   = found_q;
	assign best_ax = bax_q;
	assign best_ay = bay_q;
	assign best_bx = bbx_q;
	assign best_by = bby_q;

endmodule

@@ hw/rtl/point_set_closest_pair.sv @@
// Ordered point store with closest-pair and nearest-neighbour search.
// Points sit in a ring of cells that rotates one step a cycle past a distance unit.
// Add loads the new point directly; remove and nearest neighbour pass the stored points once,
// closest pair once over the remaining points per popped point; one transaction at a time.
// Reset empties the store; cell contents are undefined until written.
module point_set_closest_pair #(
	parameter int CAPACITY   = 64,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [15:0] point_x,
	input  logic [15:0] point_y,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [15:0] first_x,
	output logic [15:0] first_y,
	output logic [15:0] second_x,
	output logic [15:0] second_y,
	output logic [6:0]  stored_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int FB    = pscp_pkg::FIELD_BITS;
	localparam int EW    = (COORD_BITS < FB) ? COORD_BITS : FB;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t              state_q;
	pscp_pkg::func_t     op_q;
	logic                full_q;
	logic [CNT_W-1:0]    cnt_q, lim_q, steps_q;
	logic [COORD_BITS-1:0] qx_q, qy_q, ax_q, ay_q;
	logic [COORD_BITS-1:0] in_x, in_y;

	logic                rsp_valid_q;
	pscp_pkg::status_t   status_q;
	logic [FB-1:0]       fx_q, fy_q, sx_q, sy_q;
	logic [pscp_pkg::COUNT_BITS-1:0] cnt_out_q;

	pscp_pkg::ring_ctl_t ctl;
	logic [CNT_W-1:0]    ring_lim;
	logic                accept;
	logic                issue;
	logic [COORD_BITS-1:0] iss_ax, iss_ay;
	logic                head_eq;

	logic [COORD_BITS-1:0] cx [CAPACITY];
	logic [COORD_BITS-1:0] cy [CAPACITY];

	logic                found;
	logic [COORD_BITS-1:0] bax, bay, bbx, bby;

	assign in_x   = COORD_BITS'(point_x[EW-1:0]);
	assign in_y   = COORD_BITS'(point_y[EW-1:0]);
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign head_eq = (cx[0] == qx_q) && (cy[0] == qy_q);

	always_comb begin
		ctl      = '0;
		ring_lim = lim_q;
		issue    = 1'b0;
		iss_ax   = ax_q;
		iss_ay   = ay_q;
		unique case (state_q)
			S_IDLE: begin
				ring_lim = cnt_q;
				ctl.load = accept && pscp_pkg::func_t'(func) == pscp_pkg::FN_ADD
					&& cnt_q != CAP_C;
			end
			S_POP: begin
				ring_lim = cnt_q;
				ctl.rot  = (lim_q != '0);
			end
			S_SCAN: begin
				if (steps_q != '0) begin
					ctl.rot = 1'b1;
					if (op_q == pscp_pkg::FN_CLOSEST) begin
						issue = 1'b1;
					end else if (op_q == pscp_pkg::FN_NEAREST) begin
						issue  = !head_eq;
						iss_ax = qx_q;
						iss_ay = qy_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [COORD_BITS-1:0] nbx, nby;
		if (k + 1 < CAPACITY) begin : g_nb
			assign nbx = cx[k+1];
			assign nby = cy[k+1];
		end else begin : g_last
			assign nbx = cx[k];
			assign nby = cy[k];
		end
		pscp_cell #(
			.COORD_BITS(COORD_BITS),
			.CNT_W     (CNT_W),
			.IDX       (k)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.lim   (ring_lim),
			.nb_x  (nbx),
			.nb_y  (nby),
			.head_x(cx[0]),
			.head_y(cy[0]),
			.ld_x  (in_x),
			.ld_y  (in_y),
			.x     (cx[k]),
			.y     (cy[k])
		);
	end

	pscp_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.issue  (issue),
		.ax     (iss_ax),
		.ay     (iss_ay),
		.bx     (cx[0]),
		.by     (cy[0]),
		.found  (found),
		.best_ax(bax),
		.best_ay(bay),
		.best_bx(bbx),
		.best_by(bby)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= pscp_pkg::FN_ADD;
			full_q      <= 1'b0;
			cnt_q       <= '0;
			lim_q       <= '0;
			steps_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= pscp_pkg::ST_OK;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= pscp_pkg::func_t'(func);
						full_q  <= (cnt_q == CAP_C);
						lim_q   <= cnt_q;
						steps_q <= cnt_q;
						unique case (pscp_pkg::func_t'(func))
							pscp_pkg::FN_ADD: begin
								if (cnt_q != CAP_C) begin
									cnt_q <= cnt_q + ONE;
								end
								state_q <= S_DONE;
							end
							pscp_pkg::FN_CLOSEST: state_q <= S_POP;
							default:              state_q <= S_SCAN;
						endcase
					end
				end
				S_POP: begin
					if (lim_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						lim_q   <= lim_q - ONE;
						steps_q <= lim_q - ONE;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (steps_q == '0) begin
						if (op_q == pscp_pkg::FN_CLOSEST) begin
							state_q <= S_POP;
						end else begin
							if (op_q == pscp_pkg::FN_REMOVE) begin
								cnt_q <= lim_q;
							end
							state_q <= S_DRAIN;
						end
					end else begin
						steps_q <= steps_q - ONE;
						if (op_q == pscp_pkg::FN_REMOVE && head_eq) begin
							lim_q <= lim_q - ONE;
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						unique case (op_q)
							pscp_pkg::FN_ADD:
								status_q <= full_q ? pscp_pkg::ST_FULL : pscp_pkg::ST_OK;
							pscp_pkg::FN_REMOVE:
								status_q <= pscp_pkg::ST_OK;
							default:
								status_q <= found ? pscp_pkg::ST_OK : pscp_pkg::ST_NONE;
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_POP && lim_q != '0) begin
			ax_q <= cx[0];
			ay_q <= cy[0];
		end
		if (accept) begin
			qx_q <= in_x;
			qy_q <= in_y;
		end
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			cnt_out_q <= pscp_pkg::COUNT_BITS'(cnt_q);
			fx_q <= '0;
			fy_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			if (found && op_q == pscp_pkg::FN_CLOSEST) begin
				fx_q <= FB'(bax);
				fy_q <= FB'(bay);
				sx_q <= FB'(bbx);
				sy_q <= FB'(bby);
			end else if (found && op_q == pscp_pkg::FN_NEAREST) begin
				fx_q <= FB'(bbx);
				fy_q <= FB'(bby);
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign first_x      = fx_q;
	assign first_y      = fy_q;
	assign second_x     = sx_q;
	assign second_y     = sy_q;
	assign stored_count = cnt_out_q;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the closest-pair point store.
// Predicts each result from a local copy of the point list and compares it field by field.
// Depends on pscp_pkg and point_set_closest_pair.
`timescale 1ns / 1ps

module tb;

	typedef struct {
		pscp_pkg::status_t st;
		logic [15:0] fx, fy, sx, sy;
		logic [6:0]  cnt;
	} outcome_t;

	localparam int DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] func = pscp_pkg::FN_ADD;
	logic [15:0] point_x = '0;
	logic [15:0] point_y = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	logic [1:0] status;
	logic [15:0] first_x, first_y, second_x, second_y;
	logic [6:0] stored_count;

	logic [15:0] model_x[DEPTH];
	logic [15:0] model_y[DEPTH];
	int model_n = 0;
	outcome_t pending[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit draining = 1'b0;

	point_set_closest_pair uut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [32:0] dist_sq(logic [15:0] ax, logic [15:0] ay,
			logic [15:0] bx, logic [15:0] by);
		logic [15:0] dx, dy;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		return 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
	endfunction

	function automatic outcome_t apply_op(pscp_pkg::func_t op, logic [15:0] qx,
			logic [15:0] qy);
		outcome_t r;
		logic [32:0] best, d;
		bit found;
		int w;
		r = '{pscp_pkg::ST_OK, 0, 0, 0, 0, 0};
		found = 1'b0;
		best = '0;
		case (op)
			pscp_pkg::FN_ADD: begin
				if (model_n >= DEPTH) r.st = pscp_pkg::ST_FULL;
				else begin
					model_x[model_n] = qx;
					model_y[model_n] = qy;
					model_n++;
				end
			end
			pscp_pkg::FN_REMOVE: begin
				w = 0;
				for (int i = 0; i < model_n; i++)
					if (!(model_x[i] == qx && model_y[i] == qy)) begin
						model_x[w] = model_x[i];
						model_y[w] = model_y[i];
						w++;
					end
				model_n = w;
			end
			pscp_pkg::FN_CLOSEST: begin
				for (int i = 0; i < model_n; i++)
					for (int j = i + 1; j < model_n; j++) begin
						d = dist_sq(model_x[i], model_y[i], model_x[j], model_y[j]);
						if (!found || d < best) begin
							found = 1'b1;
							best = d;
							r.fx = model_x[i];
							r.fy = model_y[i];
							r.sx = model_x[j];
							r.sy = model_y[j];
						end
					end
				if (!found) r.st = pscp_pkg::ST_NONE;
			end
			default: begin
				for (int i = 0; i < model_n; i++) begin
					if (model_x[i] == qx && model_y[i] == qy) continue;
					d = dist_sq(qx, qy, model_x[i], model_y[i]);
					if (!found || d < best) begin
						found = 1'b1;
						best = d;
						r.fx = model_x[i];
						r.fy = model_y[i];
					end
				end
				if (!found) r.st = pscp_pkg::ST_NONE;
			end
		endcase
		r.cnt = 7'(model_n);
		return r;
	endfunction

	function automatic int gap_length();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
		return $urandom_range(3, 30);
	endfunction

	bit burst_mode = 1'b0;

	task automatic send_point(pscp_pkg::func_t op, logic [15:0] qx, logic [15:0] qy);
		int g;
		g = burst_mode ? 0 : gap_length();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		func <= op;
		point_x <= qx;
		point_y <= qy;
		pending.insert(pending.size(), apply_op(op, qx, qy));
		sent++;
		do @(posedge clk); while (req_stall);
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			outcome_t e;
			received++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				errors++;
			end else begin
				e = pending.pop_front();
				if (status !== e.st || first_x !== e.fx || first_y !== e.fy ||
						second_x !== e.sx || second_y !== e.sy ||
						stored_count !== e.cnt) begin
					$display("%0t: mismatch expected st=%0d f=(%0d,%0d) s=(%0d,%0d) n=%0d",
						$time, e.st, e.fx, e.fy, e.sx, e.sy, e.cnt);
					$display("%0t:          actual st=%0d f=(%0d,%0d) s=(%0d,%0d) n=%0d",
						$time, status, first_x, first_y, second_x, second_y, stored_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b1;
			stall_left <= 0;
		end else if (burst_mode) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) < 3) begin
			rsp_stall <= 1'b1;
			stall_left <= gap_length();
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_empty();
		while (pending.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_point(pscp_pkg::FN_CLOSEST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_NEAREST, 16'd5, 16'd5);
		send_point(pscp_pkg::FN_REMOVE, 16'd5, 16'd5);
		send_point(pscp_pkg::FN_ADD, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_CLOSEST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_NEAREST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_ADD, 16'hFFFF, 16'hFFFF);
		send_point(pscp_pkg::FN_NEAREST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_CLOSEST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_ADD, 16'hFFFF, 16'd0);
		send_point(pscp_pkg::FN_ADD, 16'd0, 16'hFFFF);
		send_point(pscp_pkg::FN_ADD, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_CLOSEST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_NEAREST, 16'h8000, 16'h8000);
		send_point(pscp_pkg::FN_REMOVE, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_REMOVE, 16'd1234, 16'd4321);
		send_point(pscp_pkg::FN_CLOSEST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_REMOVE, 16'hFFFF, 16'hFFFF);
		send_point(pscp_pkg::FN_REMOVE, 16'hFFFF, 16'd0);
		send_point(pscp_pkg::FN_REMOVE, 16'd0, 16'hFFFF);
		send_point(pscp_pkg::FN_NEAREST, 16'd1, 16'd1);
	endtask

	task automatic test_full_store();
		for (int i = 0; i < DEPTH + 2; i++)
			send_point(pscp_pkg::FN_ADD, 16'($urandom), 16'($urandom));
		send_point(pscp_pkg::FN_CLOSEST, 16'd0, 16'd0);
		send_point(pscp_pkg::FN_NEAREST, 16'($urandom), 16'($urandom));
		for (int i = 0; i < DEPTH; i++)
			send_point(pscp_pkg::FN_REMOVE, model_x[0], model_y[0]);
	endtask

	task automatic test_random_mix();
		logic [15:0] qx, qy;
		int k;
		for (int i = 0; i < 127; i++) begin
			burst_mode = (i >= 60 && i < 90);
			k = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0) begin
				qx = 16'($urandom_range(0, 7));
				qy = 16'($urandom_range(0, 7));
			end else begin
				qx = 16'($urandom);
				qy = 16'($urandom);
			end
			if (model_n > 0 && $urandom_range(0, 2) == 0) begin
				qx = model_x[$urandom_range(0, model_n - 1)];
				qy = model_y[$urandom_range(0, model_n - 1)];
			end
			if (k < 45) send_point(pscp_pkg::FN_ADD, qx, qy);
			else if (k < 60) send_point(pscp_pkg::FN_REMOVE, qx, qy);
			else if (k < 78) send_point(pscp_pkg::FN_CLOSEST, qx, qy);
			else send_point(pscp_pkg::FN_NEAREST, qx, qy);
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random_mix();
		req_valid <= 1'b0;
		wait_empty();
		repeat (50) @(posedge clk);
		$display("Covered %0d transactions over all four operations, including a full store.",
			sent);
		$display("Received %0d results with %0d mismatches.", received, errors);
		if (errors == 0 && pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/pscp_pkg.sv
hw/rtl/pscp_cell.sv
hw/rtl/pscp_dist.sv
hw/rtl/point_set_closest_pair.sv
bench/tb.sv
